// ===== rtl/core/adsr_pkg.sv =====
// ----------------------------------------------------------------------------
// adsr_pkg: shared types and constants of the ADSR envelope level block
// Holds the transaction payload structs, the Q1.15 full-scale value, the
// configuration register indexes and their reset values.
// ----------------------------------------------------------------------------
package adsr_pkg;

  // Field widths fixed by the interface
  localparam int ELAPSED_W = 24;
  localparam int LEVEL_W   = 16;

  // Default width of the time registers and of the time arithmetic
  localparam int TIME_BITS_DEFAULT = 24;

  // Q1.15 value that stands for 1.0
  localparam logic [LEVEL_W-1:0] FULL_SCALE = 16'd32768;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 2'd3;

  // Register reset values
  localparam logic [31:0]        ATTACK_RST  = 32'd480;
  localparam logic [31:0]        DECAY_RST   = 32'd4800;
  localparam logic [LEVEL_W-1:0] SUSTAIN_RST = 16'd16384;
  localparam logic [31:0]        RELEASE_RST = 32'd9600;

  // Input transaction payload
  typedef struct packed {
    logic [ELAPSED_W-1:0] elapsed_ticks;
    logic                 gate_on;
  } item_t;

  // Result transaction payload
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               voice_ended;
  } result_t;

endpackage

// ===== rtl/core/adsr_cfg.sv =====
// ----------------------------------------------------------------------------
// adsr_cfg: envelope configuration registers
// Decodes register writes and presents the effective segment settings:
// attack and release forced to at least one tick, sustain clamped to 1.0.
// ----------------------------------------------------------------------------
module adsr_cfg
  import adsr_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEFAULT,
  parameter int CFG_W     = (TIME_BITS > LEVEL_W) ? TIME_BITS : LEVEL_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic [TIME_BITS-1:0] attack_eff,
  output logic [TIME_BITS-1:0] decay_eff,
  output logic [LEVEL_W-1:0]   sustain_eff,
  output logic [TIME_BITS-1:0] release_eff
);

  logic [TIME_BITS-1:0] attack_ticks;
  logic [TIME_BITS-1:0] decay_ticks;
  logic [LEVEL_W-1:0]   sustain_level;
  logic [TIME_BITS-1:0] release_ticks;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_ticks  <= TIME_BITS'(ATTACK_RST);
      decay_ticks   <= TIME_BITS'(DECAY_RST);
      sustain_level <= SUSTAIN_RST;
      release_ticks <= TIME_BITS'(RELEASE_RST);
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_ATTACK:  attack_ticks  <= cfg_data[TIME_BITS-1:0];
        REG_DECAY:   decay_ticks   <= cfg_data[TIME_BITS-1:0];
        REG_SUSTAIN: sustain_level <= cfg_data[LEVEL_W-1:0];
        REG_RELEASE: release_ticks <= cfg_data[TIME_BITS-1:0];
        default:     attack_ticks  <= attack_ticks;
      endcase
    end
  end

  // A zero length is taken as one tick; sustain never exceeds full scale.
  always_comb begin
    attack_eff  = (attack_ticks == '0) ? TIME_BITS'(1) : attack_ticks;
    release_eff = (release_ticks == '0) ? TIME_BITS'(1) : release_ticks;
    decay_eff   = decay_ticks;
    sustain_eff = (sustain_level > FULL_SCALE) ? FULL_SCALE : sustain_level;
  end

endmodule

// ===== rtl/core/adsr_divider.sv =====
// ----------------------------------------------------------------------------
// adsr_divider: iterative restoring divider
// Produces one quotient bit per cycle, truncating toward zero. The divisor
// must stay stable while the division runs; done pulses when the quotient
// is ready.
// ----------------------------------------------------------------------------
module adsr_divider
  import adsr_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEFAULT,
  parameter int DW        = TIME_BITS + 15
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DW-1:0]        dividend,
  input  logic [TIME_BITS-1:0] divisor,
  output logic                 done,
  output logic [DW-1:0]        quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic                 busy;
  logic [CNT_W-1:0]     count;
  logic [TIME_BITS-1:0] rem;
  logic [DW-1:0]        quo;
  logic [TIME_BITS:0]   rem_shift;
  logic [TIME_BITS:0]   rem_diff;
  logic                 q_bit;
  logic [TIME_BITS-1:0] rem_next;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    rem_shift = {rem, quo[DW-1]};
    rem_diff  = rem_shift - {1'b0, divisor};
    q_bit     = (rem_shift >= {1'b0, divisor});
    rem_next  = q_bit ? rem_diff[TIME_BITS-1:0] : rem_shift[TIME_BITS-1:0];
  end

  // Control: counts the quotient bits still to be formed.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DW);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the quotient register doubles as the dividend shifter.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[DW-2:0], q_bit};
    end
  end

  assign quotient = quo;

endmodule

// ===== rtl/core/adsr_envelope_level.sv =====
// ----------------------------------------------------------------------------
// adsr_envelope_level: linear ADSR envelope evaluator in Q1.15
// A small sequencer picks the segment, forms the product on one multiplier
// and runs a shared bit-serial divider to scale it down.
//
//   channel  | signals                          | direction
//   ---------+----------------------------------+----------
//   item     | item_valid, item_stall, item     | in
//   result   | result_valid, result_stall, result | out
//   config   | cfg_write_en, cfg_index, cfg_data | in
//
// Attack, decay and release pass through S_EVAL, S_MUL, S_DIV and S_DONE,
// the divider forming one quotient bit per cycle; sustain and ended voices
// go from S_EVAL straight to S_DONE.
// One transaction is in work at a time; item_stall is high until it is done.
// A stalled result holds the sequencer in its final state.
// Reset (synchronous) restores the register defaults and clears the held level.
// ----------------------------------------------------------------------------
module adsr_envelope_level
  import adsr_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEFAULT,
  parameter int CFG_W     = (TIME_BITS > LEVEL_W) ? TIME_BITS : LEVEL_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int DW = TIME_BITS + 15;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  // Segment codes
  localparam logic [2:0] M_ATTACK  = 3'd0;
  localparam logic [2:0] M_DECAY   = 3'd1;
  localparam logic [2:0] M_SUSTAIN = 3'd2;
  localparam logic [2:0] M_RELEASE = 3'd3;
  localparam logic [2:0] M_ENDED   = 3'd4;

  logic [2:0]           state;
  logic [2:0]           mode;
  logic [TIME_BITS-1:0] t;
  logic                 gate;
  logic [LEVEL_W-1:0]   held_level;
  logic [LEVEL_W-1:0]   op_a;
  logic [TIME_BITS-1:0] op_b;
  logic [TIME_BITS-1:0] divisor;

  logic [TIME_BITS-1:0] attack_eff;
  logic [TIME_BITS-1:0] decay_eff;
  logic [LEVEL_W-1:0]   sustain_eff;
  logic [TIME_BITS-1:0] release_eff;

  logic                         item_accept;
  logic                         result_free;
  logic [TIME_BITS:0]           a_plus_d;
  logic [LEVEL_W+TIME_BITS-1:0] product;
  logic                         div_start;
  logic                         div_done;
  logic [DW-1:0]                quotient;
  logic [LEVEL_W-1:0]           q_sat;
  logic [LEVEL_W-1:0]           level_next;

  adsr_cfg #(
    .TIME_BITS (TIME_BITS),
    .CFG_W     (CFG_W)
  ) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .attack_eff   (attack_eff),
    .decay_eff    (decay_eff),
    .sustain_eff  (sustain_eff),
    .release_eff  (release_eff)
  );

  // The product is below 2^(TIME_BITS+15), so the top bit is always zero.
  assign product   = op_a * op_b;
  assign div_start = (state == S_MUL);

  adsr_divider #(
    .TIME_BITS (TIME_BITS),
    .DW        (DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product[DW-1:0]),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  assign item_stall  = (state != S_IDLE);
  assign item_accept = item_valid && !item_stall;
  assign result_free = !result_valid || !result_stall;
  assign a_plus_d    = {1'b0, attack_eff} + {1'b0, decay_eff};

  // Saturated quotient and the final level of the segment.
  always_comb begin
    q_sat = (quotient > DW'(FULL_SCALE)) ? FULL_SCALE : quotient[LEVEL_W-1:0];
    unique case (mode)
      M_DECAY:   level_next = FULL_SCALE - q_sat;
      M_SUSTAIN: level_next = sustain_eff;
      M_ENDED:   level_next = '0;
      default:   level_next = q_sat;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_accept) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (gate) begin
            state <= ({1'b0, t} > a_plus_d) ? S_DONE : S_MUL;
          end else begin
            state <= (t > release_eff) ? S_DONE : S_MUL;
          end
        end
        S_MUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (result_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Captured item and segment selection with the multiplier operands.
  always_ff @(posedge clk) begin
    if (item_accept) begin
      t    <= TIME_BITS'(item.elapsed_ticks);
      gate <= item.gate_on;
    end
    if (state == S_EVAL) begin
      if (gate) begin
        if ({1'b0, t} > a_plus_d) begin
          mode <= M_SUSTAIN;
        end else if (t > attack_eff) begin
          mode    <= M_DECAY;
          op_a    <= FULL_SCALE - sustain_eff;
          op_b    <= t - attack_eff;
          divisor <= decay_eff;
        end else begin
          mode    <= M_ATTACK;
          op_a    <= FULL_SCALE;
          op_b    <= t;
          divisor <= attack_eff;
        end
      end else begin
        if (t > release_eff) begin
          mode <= M_ENDED;
        end else begin
          mode    <= M_RELEASE;
          op_a    <= (held_level > FULL_SCALE) ? FULL_SCALE : held_level;
          op_b    <= release_eff - t;
          divisor <= release_eff;
        end
      end
    end
  end

  // Held level: stored by gated segments, cleared when the voice ends.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_level <= '0;
    end else if (state == S_DONE && result_free) begin
      if (mode == M_ENDED) begin
        held_level <= '0;
      end else if (mode != M_RELEASE) begin
        held_level <= level_next;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_DONE && result_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && result_free) begin
      result.level       <= level_next;
      result.voice_ended <= (mode == M_ENDED);
    end
  end

endmodule

// ===== tb/sv/adsr_envelope_level_checker.sv =====
// ----------------------------------------------------------------------------
// adsr_envelope_level_checker: scoreboard for the ADSR envelope level block
// Watches the configuration port and both transaction channels, computes the
// expected envelope value for every accepted item and compares it, field by
// field, with the results in the order they leave the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module adsr_envelope_level_checker
  import adsr_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEFAULT,
  parameter int CFG_W     = (TIME_BITS > LEVEL_W) ? TIME_BITS : LEVEL_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic                 item_stall,
  input  item_t                item,
  input  logic                 result_valid,
  input  logic                 result_stall,
  input  result_t              result,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   pending,
  output int                   checked_count,
  output int                   ended_count
);

  localparam int          REPORT_MAX = 10;
  localparam logic [63:0] Q15_ONE    = 64'd32768;
  localparam logic [63:0] TIME_MASK  = (64'd1 << TIME_BITS) - 64'd1;

  // Local copy of the registers and of the held level
  logic [TIME_BITS-1:0] attack_len;
  logic [TIME_BITS-1:0] decay_len;
  logic [TIME_BITS-1:0] release_len;
  logic [LEVEL_W-1:0]   sustain_reg;
  logic [LEVEL_W-1:0]   held_level;

  // Envelope values still owed by the block, oldest first
  result_t owed_levels[$];

  function automatic logic [63:0] clip_q15(input logic [63:0] v);
    return (v > Q15_ONE) ? Q15_ONE : v;
  endfunction

  // Envelope value for one item; gate-on items and ended voices update the
  // held level as a side effect.
  function automatic result_t envelope_level_of(input item_t it);
    logic [63:0] t;
    logic [63:0] a;
    logic [63:0] d;
    logic [63:0] s;
    logic [63:0] r;
    logic [63:0] drop;
    logic [63:0] lvl;
    result_t     res;
    t = 64'(it.elapsed_ticks) & TIME_MASK;
    res.voice_ended = 1'b0;
    if (it.gate_on) begin
      a = (attack_len == '0) ? 64'd1 : 64'(attack_len);
      d = 64'(decay_len);
      s = clip_q15(64'(sustain_reg));
      if (t > a + d) begin
        lvl = s;
      end else if (t > a) begin
        // Inside the decay segment the decay length is never zero.
        drop = ((Q15_ONE - s) * (t - a)) / d;
        lvl  = Q15_ONE - clip_q15(drop);
      end else begin
        lvl = clip_q15((t * Q15_ONE) / a);
      end
      held_level = lvl[LEVEL_W-1:0];
    end else begin
      r = (release_len == '0) ? 64'd1 : 64'(release_len);
      if (t > r) begin
        lvl             = 64'd0;
        held_level      = '0;
        res.voice_ended = 1'b1;
      end else begin
        lvl = clip_q15((clip_q15(64'(held_level)) * (r - t)) / r);
      end
    end
    res.level = lvl[LEVEL_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    result_t owed;
    if (rst) begin
      attack_len    = TIME_BITS'(ATTACK_RST);
      decay_len     = TIME_BITS'(DECAY_RST);
      sustain_reg   = SUSTAIN_RST;
      release_len   = TIME_BITS'(RELEASE_RST);
      held_level    = '0;
      owed_levels.delete();
      fail_count    = 0;
      checked_count = 0;
      ended_count   = 0;
      pending      <= 0;
    end else begin
      // Result transaction: compare with the oldest owed value.
      if (result_valid && !result_stall) begin
        if (owed_levels.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX) begin
            $display("[%0t] unexpected result: level %0d ended %0b",
                     $realtime, result.level, result.voice_ended);
          end
        end else begin
          owed = owed_levels.pop_front();
          checked_count++;
          if (owed.voice_ended) begin
            ended_count++;
          end
          if (result.level !== owed.level || result.voice_ended !== owed.voice_ended) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
              $display("[%0t] mismatch: expected level %0d ended %0b, got level %0d ended %0b",
                       $realtime, owed.level, owed.voice_ended, result.level,
                       result.voice_ended);
            end
          end
        end
      end

      // Item transaction: predict with the settings in force before this edge.
      if (item_valid && !item_stall) begin
        owed_levels.push_back(envelope_level_of(item));
      end

      // Register writes
      if (cfg_write_en) begin
        case (cfg_index)
          REG_ATTACK:  attack_len  = cfg_data[TIME_BITS-1:0];
          REG_DECAY:   decay_len   = cfg_data[TIME_BITS-1:0];
          REG_SUSTAIN: sustain_reg = cfg_data[LEVEL_W-1:0];
          REG_RELEASE: release_len = cfg_data[TIME_BITS-1:0];
          default: ;
        endcase
      end

      pending <= owed_levels.size();
    end
  end

endmodule

// ===== tb/sv/adsr_envelope_level_test.sv =====
// ----------------------------------------------------------------------------
// adsr_envelope_level_test: top-level testbench of the ADSR envelope block
// Drives directed boundary items and random note sequences (attack, decay,
// sustain, release up to the voice end) over many register settings, with
// random idling on both channels and one long stall; a separate checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module adsr_envelope_level_test
  import adsr_pkg::*;
();

  localparam int TIME_BITS        = TIME_BITS_DEFAULT;
  localparam int CFG_W            = (TIME_BITS > LEVEL_W) ? TIME_BITS : LEVEL_W;
  localparam int CYCLE_LIMIT      = 1000000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES    = 4;
  localparam int TAIL_CYCLES      = 60;
  localparam int PHASES           = 3;
  localparam int SETTINGS_PER_PHASE = 6;

  localparam logic [ELAPSED_W-1:0] TICK_MAX = '1;
  localparam logic [CFG_W-1:0]     TIME_MAX = CFG_W'((64'd1 << TIME_BITS) - 64'd1);

  logic                 clk;
  logic                 rst;
  logic                 item_valid;
  logic                 item_stall;
  item_t                item;
  logic                 result_valid;
  logic                 result_stall;
  result_t              result;
  logic                 cfg_write_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int fail_count;
  int pending;
  int checked_count;
  int ended_count;

  // Idling controls of the sender and the receiver
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          long_hold_req;
  int          cycle_count;
  int          setting_count;

  // Register values currently loaded, used only to shape note sequences
  longint unsigned cur_attack;
  longint unsigned cur_decay;
  longint unsigned cur_release;

  adsr_envelope_level #(
    .TIME_BITS (TIME_BITS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  adsr_envelope_level_checker #(
    .TIME_BITS (TIME_BITS)
  ) envelope_check (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .item          (item),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count),
    .ended_count   (ended_count)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random stalls, or one long hold-off when requested.
  initial begin
    int n;
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        for (n = 0; n < LONG_HOLD_CYCLES; n++) begin
          result_stall <= 1'b1;
          @(posedge clk);
        end
      end
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic logic [ELAPSED_W-1:0] clip_ticks(input longint unsigned v);
    return (v > TICK_MAX) ? TICK_MAX : ELAPSED_W'(v);
  endfunction

  // Offer one item transaction and return at the edge that accepts it.
  task automatic offer_item(input logic [ELAPSED_W-1:0] ticks, input logic gate);
    item_t it;
    it.elapsed_ticks = ticks;
    it.gate_on       = gate;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // Stop offering and wait until every owed result has been taken.
  task automatic wait_idle(input int extra);
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    @(posedge clk);
  endtask

  // Load all four registers; only called while the block is idle.
  task automatic load_envelope(input logic [CFG_W-1:0] atk, input logic [CFG_W-1:0] dec,
                               input logic [CFG_W-1:0] sus, input logic [CFG_W-1:0] rel);
    write_reg(REG_ATTACK, atk);
    write_reg(REG_DECAY, dec);
    write_reg(REG_SUSTAIN, sus);
    write_reg(REG_RELEASE, rel);
    cfg_write_en <= 1'b0;
    cur_attack  = (atk[TIME_BITS-1:0] == '0) ? 1 : atk[TIME_BITS-1:0];
    cur_decay   = dec[TIME_BITS-1:0];
    cur_release = (rel[TIME_BITS-1:0] == '0) ? 1 : rel[TIME_BITS-1:0];
    setting_count++;
  endtask

  // Durations from very short up to the full register width.
  function automatic logic [CFG_W-1:0] pick_duration();
    case ($urandom_range(3))
      0:       return CFG_W'($urandom_range(1, 16));
      1:       return CFG_W'($urandom_range(1, 2000));
      2:       return CFG_W'($urandom_range(1, 200000));
      default: return CFG_W'($urandom) & TIME_MAX;
    endcase
  endfunction

  // Sustain levels, including values above full scale and stray high bits.
  function automatic logic [CFG_W-1:0] pick_sustain();
    case ($urandom_range(3))
      0:       return CFG_W'($urandom_range(0, 32768));
      1:       return CFG_W'($urandom);
      2:       return CFG_W'(FULL_SCALE);
      default: return '0;
    endcase
  endfunction

  // One key press: rising times through attack and decay into sustain,
  // then release times that usually run past the end of the voice.
  task automatic play_note();
    int              on_count;
    int              off_count;
    int              k;
    int unsigned     step_max;
    longint unsigned span;
    longint unsigned t;
    on_count = $urandom_range(3, 7);
    span     = cur_attack + cur_decay + cur_attack / 4 + 1;
    step_max = int'(2 * span / on_count) + 1;
    t        = $urandom_range(0, 3);
    for (k = 0; k < on_count; k++) begin
      case ($urandom_range(7))
        0:       offer_item(clip_ticks(cur_attack), 1'b1);
        1:       offer_item(clip_ticks(cur_attack + cur_decay + $urandom_range(1)), 1'b1);
        default: offer_item(clip_ticks(t), 1'b1);
      endcase
      t += $urandom_range(1, step_max);
    end
    off_count = $urandom_range(2, 5);
    span      = cur_release + cur_release / 4 + 1;
    step_max  = int'(2 * span / off_count) + 1;
    t         = $urandom_range(0, 2);
    for (k = 0; k < off_count; k++) begin
      offer_item(clip_ticks(t), 1'b0);
      t += $urandom_range(1, step_max);
    end
    if ($urandom_range(1)) begin
      offer_item(clip_ticks(cur_release + $urandom_range(0, 2)), 1'b0);
    end
  endtask

  // Stimulus
  initial begin
    int phase;
    int c;
    rst           = 1'b1;
    item_valid    = 1'b0;
    item          = '0;
    cfg_write_en  = 1'b0;
    cfg_index     = REG_ATTACK;
    cfg_data      = '0;
    long_hold_req = 1'b0;
    send_idle_pct = 38;
    recv_idle_pct = 45;
    setting_count = 1;
    cur_attack    = ATTACK_RST;
    cur_decay     = DECAY_RST;
    cur_release   = RELEASE_RST;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: segment boundaries, release from sustain and from
    // inside the attack, and a second release after the voice has ended.
    offer_item(24'd0, 1'b1);
    offer_item(24'd240, 1'b1);
    offer_item(24'd480, 1'b1);
    offer_item(24'd481, 1'b1);
    offer_item(24'd5280, 1'b1);
    offer_item(24'd5281, 1'b1);
    offer_item(TICK_MAX, 1'b1);
    offer_item(24'd0, 1'b0);
    offer_item(24'd4800, 1'b0);
    offer_item(24'd9600, 1'b0);
    offer_item(24'd9601, 1'b0);
    offer_item(TICK_MAX, 1'b0);
    offer_item(24'd100, 1'b1);
    offer_item(24'd100, 1'b0);

    // Zero attack and release, empty decay, sustain above full scale.
    wait_idle(SETTLE_CYCLES);
    load_envelope('0, '0, CFG_W'(16'hFFFF), '0);
    offer_item(24'd0, 1'b1);
    offer_item(24'd1, 1'b1);
    offer_item(24'd2, 1'b1);
    offer_item(24'd0, 1'b0);
    offer_item(24'd1, 1'b0);
    offer_item(24'd2, 1'b0);

    // Longest durations with a zero sustain level.
    wait_idle(SETTLE_CYCLES);
    load_envelope(TIME_MAX, TIME_MAX, '0, TIME_MAX);
    offer_item(TICK_MAX, 1'b1);
    offer_item(24'd0, 1'b0);
    offer_item(TICK_MAX, 1'b0);
    offer_item(24'd1, 1'b1);

    // Random notes and stray items under three idling patterns.
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 38;
          recv_idle_pct = 45;
        end
        1: begin
          send_idle_pct = 45;
          recv_idle_pct = 38;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (c = 0; c < SETTINGS_PER_PHASE; c++) begin
        wait_idle(SETTLE_CYCLES);
        load_envelope(pick_duration(), pick_duration(), pick_sustain(), pick_duration());
        // Hold the result side while items keep coming, so the input backs up.
        if (phase == 1 && c == 0) begin
          long_hold_req = 1'b1;
        end
        repeat (3) play_note();
        repeat (4) offer_item(ELAPSED_W'($urandom), 1'($urandom_range(1)));
      end
    end

    wait_idle(TAIL_CYCLES);
    $display("Checked %0d envelope values (%0d voice ends) over %0d register settings.",
             checked_count, ended_count, setting_count);
    if (pending != 0) begin
      $display("%0d expected results never arrived", pending);
    end
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/adsr_pkg.sv
rtl/core/adsr_cfg.sv
rtl/core/adsr_divider.sv
rtl/core/adsr_envelope_level.sv
tb/sv/adsr_envelope_level_checker.sv
tb/sv/adsr_envelope_level_test.sv
